/* rtl/gtbm_pkg.sv */
// ----------------------------------------------------------------------------
// gtbm_pkg
// Shared constants, command struct and pixel address helper for the glyph
// tile matcher.
// ----------------------------------------------------------------------------
package gtbm_pkg;

    // Geometry
    localparam int GLYPH_WIDTH   = 8;
    localparam int GLYPH_HEIGHT  = 16;
    localparam int MAX_GLYPHS    = 128;
    localparam int PIX_PER_GLYPH = GLYPH_WIDTH * GLYPH_HEIGHT;
    localparam int PIX_MAX       = 255;

    // Fixed port field widths
    localparam int PIX_BITS       = 8;
    localparam int IDX_BITS       = 7;
    localparam int WEIGHT_BITS    = 8;
    localparam int SCORE_OUT_BITS = 24;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 8;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_MODE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ABS_WEIGHT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIGNED_WEIGHT = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GLYPH_COUNT   = 2'd3;

    localparam logic [WEIGHT_BITS-1:0]   ABS_WEIGHT_RST    = 8'd1;
    localparam logic [WEIGHT_BITS-1:0]   SIGNED_WEIGHT_RST = 8'd1;
    localparam logic [CFG_DATA_BITS-1:0] GLYPH_COUNT_RST   = 8'd128;

    // Request opcodes
    localparam logic CMD_FONT = 1'b0;
    localparam logic CMD_TILE = 1'b1;

    // Match modes
    localparam logic MODE_SAD      = 1'b0;
    localparam logic MODE_WEIGHTED = 1'b1;

    // Derived widths
    localparam int COL_BITS      = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
    localparam int ROW_BITS      = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
    localparam int GLYPH_BITS    = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int COUNT_BITS    = $clog2(MAX_GLYPHS + 1);
    localparam int FONT_ROWS     = MAX_GLYPHS * GLYPH_HEIGHT;
    localparam int FADDR_BITS    = (FONT_ROWS > 1) ? $clog2(FONT_ROWS) : 1;
    localparam int ROW_DATA_BITS = GLYPH_WIDTH * PIX_BITS;
    localparam int ROWSUM_BITS   = $clog2(PIX_MAX * GLYPH_WIDTH + 1);
    localparam int ROWSD_BITS    = ROWSUM_BITS + 1;
    localparam int SAD_BITS      = $clog2(PIX_MAX * PIX_PER_GLYPH + 1);
    localparam int SD_BITS       = SAD_BITS + 1;
    localparam int SCORE_BITS    = SAD_BITS + WEIGHT_BITS + 1;
    localparam int SAD_WORST     = PIX_MAX * PIX_PER_GLYPH;

    // Cycles from the last row read until the best score is final
    localparam int DRAIN_CYCLES = 4;
    localparam int DRAIN_BITS   = 2;

    typedef struct packed {
        logic                  wr_font;
        logic                  wr_tile;
        logic                  init;
        logic                  rd;
        logic                  rd_first;
        logic                  rd_last;
        logic [GLYPH_BITS-1:0] rd_glyph;
        logic [ROW_BITS-1:0]   rd_row;
    } t_dp_cmd;

    typedef struct packed {
        logic                in_range;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
    } t_pix_loc;

    // Row/column of a row-major pixel index; compares against constants only.
    function automatic t_pix_loc pix_locate(input logic [IDX_BITS-1:0] p);
        t_pix_loc loc;
        loc          = '0;
        loc.in_range = (int'(p) < PIX_PER_GLYPH);
        for (int r = 0; r < GLYPH_HEIGHT; r++) begin
            if (int'(p) >= r * GLYPH_WIDTH) begin
                loc.row = ROW_BITS'(r);
                loc.col = COL_BITS'(int'(p) - r * GLYPH_WIDTH);
            end
        end
        return loc;
    endfunction

endpackage

/* rtl/gtbm_ctrl.sv */
// ----------------------------------------------------------------------------
// gtbm_ctrl
// Sequencer: walks glyph rows during a match, waits out the datapath
// pipeline and raises the result strobe.
// ----------------------------------------------------------------------------
module gtbm_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_command,
    input  logic                              i_tile_done,
    input  logic [gtbm_pkg::COUNT_BITS-1:0]   i_count,
    output gtbm_pkg::t_dp_cmd                 o_cmd,
    output logic                              o_busy,
    output logic                              o_strobe
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    localparam int GB = gtbm_pkg::GLYPH_BITS;
    localparam int RB = gtbm_pkg::ROW_BITS;
    localparam int CB = gtbm_pkg::COUNT_BITS;
    localparam int DB = gtbm_pkg::DRAIN_BITS;

    logic [1:0]    r_state,  n_state;
    logic [GB-1:0] r_glyph,  n_glyph;
    logic [RB-1:0] r_row,    n_row;
    logic [DB-1:0] r_drain,  n_drain;
    logic          r_strobe, n_strobe;

    logic w_match;
    logic w_last_row;
    logic w_last_glyph;

    assign w_match      = i_accept && (i_command == gtbm_pkg::CMD_TILE) && i_tile_done;
    assign w_last_row   = (r_row == RB'(gtbm_pkg::GLYPH_HEIGHT - 1));
    assign w_last_glyph = (CB'(r_glyph) == (i_count - CB'(1)));

    always_comb begin
        n_state  = r_state;
        n_glyph  = r_glyph;
        n_row    = r_row;
        n_drain  = r_drain;
        n_strobe = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_match) begin
                    if (i_count == '0) begin
                        n_strobe = 1'b1;
                    end else begin
                        n_state = S_RUN;
                        n_glyph = '0;
                        n_row   = '0;
                    end
                end
            end
            S_RUN: begin
                if (w_last_row) begin
                    n_row = '0;
                    if (w_last_glyph) begin
                        n_state = S_DRAIN;
                        n_drain = '0;
                    end else begin
                        n_glyph = r_glyph + GB'(1);
                    end
                end else begin
                    n_row = r_row + RB'(1);
                end
            end
            S_DRAIN: begin
                if (r_drain == DB'(gtbm_pkg::DRAIN_CYCLES - 1)) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                end else begin
                    n_drain = r_drain + DB'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_glyph  <= '0;
            r_row    <= '0;
            r_drain  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_glyph  <= n_glyph;
            r_row    <= n_row;
            r_drain  <= n_drain;
            r_strobe <= n_strobe;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.wr_font  = i_accept && (i_command == gtbm_pkg::CMD_FONT);
        o_cmd.wr_tile  = i_accept && (i_command == gtbm_pkg::CMD_TILE);
        o_cmd.init     = w_match;
        o_cmd.rd       = (r_state == S_RUN);
        o_cmd.rd_first = (r_row == '0);
        o_cmd.rd_last  = w_last_row;
        o_cmd.rd_glyph = r_glyph;
        o_cmd.rd_row   = r_row;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule

/* rtl/gtbm_dpath.sv */
// ----------------------------------------------------------------------------
// gtbm_dpath
// Font and tile row memories, row SAD/sum pipeline, glyph accumulator,
// weighting multipliers and best-score tracking.
// ----------------------------------------------------------------------------
module gtbm_dpath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  gtbm_pkg::t_dp_cmd                     i_cmd,
    input  logic [gtbm_pkg::IDX_BITS-1:0]         i_glyph_index,
    input  logic [gtbm_pkg::IDX_BITS-1:0]         i_pixel_index,
    input  logic [gtbm_pkg::PIX_BITS-1:0]         i_pixel_value,
    input  logic                                  i_match_mode,
    input  logic [gtbm_pkg::WEIGHT_BITS-1:0]      i_abs_weight,
    input  logic [gtbm_pkg::WEIGHT_BITS-1:0]      i_signed_weight,
    output logic [gtbm_pkg::IDX_BITS-1:0]         o_best_glyph,
    output logic [gtbm_pkg::SCORE_OUT_BITS-1:0]   o_best_score
);

    localparam int PB   = gtbm_pkg::PIX_BITS;
    localparam int GB   = gtbm_pkg::GLYPH_BITS;
    localparam int FAB  = gtbm_pkg::FADDR_BITS;
    localparam int RDB  = gtbm_pkg::ROW_DATA_BITS;
    localparam int RSB  = gtbm_pkg::ROWSUM_BITS;
    localparam int RSDB = gtbm_pkg::ROWSD_BITS;
    localparam int SAB  = gtbm_pkg::SAD_BITS;
    localparam int SDB  = gtbm_pkg::SD_BITS;
    localparam int SCB  = gtbm_pkg::SCORE_BITS;
    localparam int OB   = gtbm_pkg::SCORE_OUT_BITS;
    localparam int IB   = gtbm_pkg::IDX_BITS;
    localparam int GCMP = gtbm_pkg::IDX_BITS + 2;
    localparam int SEXT = SCB + OB;
    localparam int GEXT = GB + IB;

    // ---- write decode ----
    gtbm_pkg::t_pix_loc w_loc;
    logic               w_font_ok;
    logic [FAB-1:0]     w_font_waddr;
    logic [FAB-1:0]     w_font_raddr;

    assign w_loc        = gtbm_pkg::pix_locate(i_pixel_index);
    assign w_font_ok    = w_loc.in_range &&
                          (GCMP'(i_glyph_index) < GCMP'(gtbm_pkg::MAX_GLYPHS));
    assign w_font_waddr = FAB'(int'(i_glyph_index) * gtbm_pkg::GLYPH_HEIGHT + int'(w_loc.row));
    assign w_font_raddr = FAB'(int'(i_cmd.rd_glyph) * gtbm_pkg::GLYPH_HEIGHT
                               + int'(i_cmd.rd_row));

    // ---- memories, one glyph row per word, byte-lane writes ----
    logic [RDB-1:0] r_font_mem [gtbm_pkg::FONT_ROWS];
    logic [RDB-1:0] r_tile_mem [gtbm_pkg::GLYPH_HEIGHT];
    logic [RDB-1:0] r_font_q;
    logic [RDB-1:0] r_tile_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_font && w_font_ok) begin
            r_font_mem[w_font_waddr][int'(w_loc.col) * PB +: PB] <= i_pixel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_tile && w_loc.in_range) begin
            r_tile_mem[w_loc.row][int'(w_loc.col) * PB +: PB] <= i_pixel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_font_q <= r_font_mem[w_font_raddr];
            r_tile_q <= r_tile_mem[i_cmd.rd_row];
        end
    end

    // ---- stage A: read data ----
    logic          r_a_vld;
    logic          r_a_first;
    logic          r_a_last;
    logic [GB-1:0] r_a_glyph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.rd;
        end
        r_a_first <= i_cmd.rd_first;
        r_a_last  <= i_cmd.rd_last;
        r_a_glyph <= i_cmd.rd_glyph;
    end

    // ---- stage B: per-row sums ----
    logic [RSB-1:0]         w_row_abs;
    logic signed [RSDB-1:0] w_row_sd;

    always_comb begin
        logic signed [PB:0] d;
        logic signed [PB:0] ad;
        w_row_abs = '0;
        w_row_sd  = '0;
        for (int l = 0; l < gtbm_pkg::GLYPH_WIDTH; l++) begin
            d         = $signed({1'b0, r_tile_q[l*PB +: PB]})
                      - $signed({1'b0, r_font_q[l*PB +: PB]});
            ad        = (d < 0) ? -d : d;
            w_row_abs = w_row_abs + RSB'(ad[PB-1:0]);
            w_row_sd  = w_row_sd + RSDB'(d);
        end
    end

    logic                   r_b_vld;
    logic                   r_b_first;
    logic                   r_b_last;
    logic [GB-1:0]          r_b_glyph;
    logic [RSB-1:0]         r_b_abs;
    logic signed [RSDB-1:0] r_b_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_first <= r_a_first;
        r_b_last  <= r_a_last;
        r_b_glyph <= r_a_glyph;
        r_b_abs   <= w_row_abs;
        r_b_sd    <= w_row_sd;
    end

    // ---- stage C: per-glyph accumulation ----
    logic                  r_c_vld;
    logic [GB-1:0]         r_c_glyph;
    logic [SAB-1:0]        r_sad;
    logic signed [SDB-1:0] r_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld && r_b_last;
        end
        if (r_b_vld) begin
            if (r_b_first) begin
                r_sad <= SAB'(r_b_abs);
                r_sd  <= SDB'(r_b_sd);
            end else begin
                r_sad <= r_sad + SAB'(r_b_abs);
                r_sd  <= r_sd + SDB'(r_b_sd);
            end
        end
        r_c_glyph <= r_b_glyph;
    end

    // ---- stage D: weighting ----
    logic [SAB-1:0] w_asd;
    logic           r_d_vld;
    logic [GB-1:0]  r_d_glyph;
    logic [SCB-1:0] r_prod_a;
    logic [SCB-1:0] r_prod_s;

    assign w_asd = (r_sd < 0) ? SAB'(-r_sd) : SAB'(r_sd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_glyph <= r_c_glyph;
        if (i_match_mode == gtbm_pkg::MODE_WEIGHTED) begin
            r_prod_a <= SCB'(r_sad) * SCB'(i_abs_weight);
            r_prod_s <= SCB'(w_asd) * SCB'(i_signed_weight);
        end else begin
            r_prod_a <= SCB'(r_sad);
            r_prod_s <= '0;
        end
    end

    // ---- stage E: best tracking, strict less keeps the earlier glyph ----
    localparam int WEIGHT_SUM_BITS = gtbm_pkg::WEIGHT_BITS + 1;

    logic [SCB-1:0] w_score;
    logic [SCB-1:0] w_start;
    logic [WEIGHT_SUM_BITS-1:0] w_wsum;
    logic [SCB-1:0] r_best_score;
    logic [GB-1:0]  r_best_glyph;

    assign w_score = r_prod_a + r_prod_s;
    assign w_wsum  = WEIGHT_SUM_BITS'(i_abs_weight) + WEIGHT_SUM_BITS'(i_signed_weight);
    assign w_start = (i_match_mode == gtbm_pkg::MODE_WEIGHTED)
                   ? SCB'(w_wsum) * SCB'(gtbm_pkg::SAD_WORST)
                   : SCB'(gtbm_pkg::SAD_WORST);

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.init) begin
            r_best_score <= w_start;
            r_best_glyph <= '0;
        end else if (r_d_vld && (w_score < r_best_score)) begin
            r_best_score <= w_score;
            r_best_glyph <= r_d_glyph;
        end
    end

    // ---- output: glyph masked to field, score saturated ----
    logic [SEXT-1:0] w_sext;
    logic [GEXT-1:0] w_gext;

    assign w_sext       = SEXT'(r_best_score);
    assign w_gext       = GEXT'(r_best_glyph);
    assign o_best_score = (|w_sext[SEXT-1:OB]) ? '1 : w_sext[OB-1:0];
    assign o_best_glyph = w_gext[IB-1:0];

endmodule

/* rtl/glyph_tile_best_match.sv */
// ----------------------------------------------------------------------------
// glyph_tile_best_match
// Best-matching font glyph for one tile by sum of absolute differences, or by a weighted score in weighted mode.
// ----------------------------------------------------------------------------
// Each accepted request (start high while busy is low) writes one 8-bit pixel,
// into the font (i_command = font) or into the tile (i_command = tile). A
// pixel write leaves busy low, so requests may follow on every clock. A tile
// request with i_tile_done set stores its pixel and then scores the first
// glyph_count glyphs (capped at the font size) against the tile, one glyph
// row per clock, a rate set by the single row port of the font memory; busy
// is high while the glyphs are scored and the pipeline drains. The result is
// then shown on o_best_glyph/o_best_score for exactly one cycle with o_strobe
// high; there is no way to hold it off, so the receiver must take it in that
// cycle. With glyph_count zero the result (glyph 0, worst score) comes the
// cycle after the request. Font and tile pixels must be written before a
// match reads them; memories are not cleared at reset. Configuration writes
// must go in only while busy is low; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module glyph_tile_best_match (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request port
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_command,
    input  logic [gtbm_pkg::IDX_BITS-1:0]         i_glyph_index,
    input  logic [gtbm_pkg::IDX_BITS-1:0]         i_pixel_index,
    input  logic [gtbm_pkg::PIX_BITS-1:0]         i_pixel_value,
    input  logic                                  i_tile_done,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [gtbm_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [gtbm_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    // result
    output logic                                  o_strobe,
    output logic [gtbm_pkg::IDX_BITS-1:0]         o_best_glyph,
    output logic [gtbm_pkg::SCORE_OUT_BITS-1:0]   o_best_score
);

    localparam int CB   = gtbm_pkg::COUNT_BITS;
    localparam int CMPW = gtbm_pkg::COUNT_BITS + gtbm_pkg::CFG_DATA_BITS;

    // Configuration registers
    logic                                 r_match_mode;
    logic [gtbm_pkg::WEIGHT_BITS-1:0]     r_abs_weight;
    logic [gtbm_pkg::WEIGHT_BITS-1:0]     r_signed_weight;
    logic [gtbm_pkg::CFG_DATA_BITS-1:0]   r_glyph_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_mode    <= gtbm_pkg::MODE_SAD;
            r_abs_weight    <= gtbm_pkg::ABS_WEIGHT_RST;
            r_signed_weight <= gtbm_pkg::SIGNED_WEIGHT_RST;
            r_glyph_count   <= gtbm_pkg::GLYPH_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gtbm_pkg::CFG_MATCH_MODE:    r_match_mode    <= i_cfg_data[0];
                gtbm_pkg::CFG_ABS_WEIGHT:    r_abs_weight    <= i_cfg_data;
                gtbm_pkg::CFG_SIGNED_WEIGHT: r_signed_weight <= i_cfg_data;
                gtbm_pkg::CFG_GLYPH_COUNT:   r_glyph_count   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Glyph count capped at the font size
    logic [CB-1:0] w_count;
    assign w_count = (CMPW'(r_glyph_count) > CMPW'(gtbm_pkg::MAX_GLYPHS))
                   ? CB'(gtbm_pkg::MAX_GLYPHS) : CB'(r_glyph_count);

    logic w_accept;
    assign w_accept = start && !busy;

    gtbm_pkg::t_dp_cmd w_cmd;

    // Sequencer: row/glyph walk, pipeline drain, result strobe
    gtbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_command   (i_command),
        .i_tile_done (i_tile_done),
        .i_count     (w_count),
        .o_cmd       (w_cmd),
        .o_busy      (busy),
        .o_strobe    (o_strobe)
    );

    // Memories and scoring pipeline (read, row sums, accumulate, weight, compare)
    gtbm_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_glyph_index   (i_glyph_index),
        .i_pixel_index   (i_pixel_index),
        .i_pixel_value   (i_pixel_value),
        .i_match_mode    (r_match_mode),
        .i_abs_weight    (r_abs_weight),
        .i_signed_weight (r_signed_weight),
        .o_best_glyph    (o_best_glyph),
        .o_best_score    (o_best_score)
    );

`ifndef SYNTH
    // A result only ever leaves once the sequencer is back at rest.
    a_strobe_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // Font writes never produce a result.
    a_font_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == gtbm_pkg::CMD_FONT)) |=> !o_strobe)
        else $error("result after font write");

    // Empty search answers on the next cycle with glyph 0.
    a_empty_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == gtbm_pkg::CMD_TILE) && i_tile_done && (w_count == '0))
        |=> (o_strobe && (o_best_glyph == '0)))
        else $error("empty search did not answer glyph 0");
`endif

endmodule

/* tb/tb_glyph_tile_best_match.sv */
// ----------------------------------------------------------------------------
// tb_glyph_tile_best_match
// Self-checking bench for the glyph/tile best-match engine: pixel requests
// come from a queue, every tile-done request is scored by a local model of
// the font and tile, and each strobed result is checked against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_glyph_tile_best_match;

    typedef struct packed {
        logic                          cmd;
        logic [gtbm_pkg::IDX_BITS-1:0] glyph;
        logic [gtbm_pkg::IDX_BITS-1:0] pix;
        logic [gtbm_pkg::PIX_BITS-1:0] val;
        logic                          done;
    } t_pixel_req;

    typedef struct packed {
        logic [gtbm_pkg::IDX_BITS-1:0]       glyph;
        logic [gtbm_pkg::SCORE_OUT_BITS-1:0] score;
    } t_match;

    typedef enum {FILL_FLAT, FILL_TILE, FILL_NEAR_TILE, FILL_RANDOM} t_fill_style;

    // DUT pins; all inputs known from time zero
    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                start         = 1'b0;
    logic                                busy;
    logic                                i_command     = gtbm_pkg::CMD_FONT;
    logic [gtbm_pkg::IDX_BITS-1:0]       i_glyph_index = '0;
    logic [gtbm_pkg::IDX_BITS-1:0]       i_pixel_index = '0;
    logic [gtbm_pkg::PIX_BITS-1:0]       i_pixel_value = '0;
    logic                                i_tile_done   = 1'b0;
    logic                                i_cfg_we      = 1'b0;
    logic [gtbm_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx     = gtbm_pkg::CFG_MATCH_MODE;
    logic [gtbm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data    = '0;
    logic                                o_strobe;
    logic [gtbm_pkg::IDX_BITS-1:0]       o_best_glyph;
    logic [gtbm_pkg::SCORE_OUT_BITS-1:0] o_best_score;

    // Request stream and expected results
    t_pixel_req pixel_requests[$];
    t_match     pending_matches[$];
    t_pixel_req req_on_bus;
    int         idle_pct   = 30;
    int         fail_count = 0;

    // Model copy of the block state and its registers
    logic [gtbm_pkg::PIX_BITS-1:0] font_shadow[gtbm_pkg::MAX_GLYPHS*gtbm_pkg::PIX_PER_GLYPH];
    logic [gtbm_pkg::PIX_BITS-1:0] tile_shadow[gtbm_pkg::PIX_PER_GLYPH];
    logic                               cur_mode     = gtbm_pkg::MODE_SAD;
    logic [gtbm_pkg::WEIGHT_BITS-1:0]   cur_abs_w    = gtbm_pkg::ABS_WEIGHT_RST;
    logic [gtbm_pkg::WEIGHT_BITS-1:0]   cur_signed_w = gtbm_pkg::SIGNED_WEIGHT_RST;
    logic [gtbm_pkg::CFG_DATA_BITS-1:0] cur_count    = gtbm_pkg::GLYPH_COUNT_RST;

    // Tile as the stimulus side sees it, ahead of the DUT
    logic [gtbm_pkg::PIX_BITS-1:0] gen_tile[gtbm_pkg::PIX_PER_GLYPH];

    glyph_tile_best_match uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_glyph_index (i_glyph_index),
        .i_pixel_index (i_pixel_index),
        .i_pixel_value (i_pixel_value),
        .i_tile_done   (i_tile_done),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_best_glyph  (o_best_glyph),
        .o_best_score  (o_best_score)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Model: apply one accepted request; a tile-done request scores glyphs
    // 0..count-1 (count capped at the font size) and queues the winner.
    // Strict less-than keeps the earliest glyph on ties, and a search where
    // nothing beats the starting score reports glyph 0 with that score.
    // ------------------------------------------------------------------------
    task automatic score_request(input t_pixel_req r);
        int     n_glyphs;
        int     best_g;
        int     d;
        longint worst;
        longint best;
        longint sad;
        longint sd;
        longint score;
        t_match m;
        if (r.cmd == gtbm_pkg::CMD_FONT) begin
            if (int'(r.glyph) < gtbm_pkg::MAX_GLYPHS && int'(r.pix) < gtbm_pkg::PIX_PER_GLYPH)
                font_shadow[int'(r.glyph) * gtbm_pkg::PIX_PER_GLYPH + int'(r.pix)] = r.val;
        end else begin
            if (int'(r.pix) < gtbm_pkg::PIX_PER_GLYPH)
                tile_shadow[int'(r.pix)] = r.val;
            if (r.done) begin
                n_glyphs = (int'(cur_count) > gtbm_pkg::MAX_GLYPHS)
                         ? gtbm_pkg::MAX_GLYPHS : int'(cur_count);
                worst = longint'(gtbm_pkg::PIX_MAX) * gtbm_pkg::PIX_PER_GLYPH;
                if (cur_mode == gtbm_pkg::MODE_WEIGHTED)
                    worst = worst * (longint'(cur_abs_w) + longint'(cur_signed_w));
                best   = worst;
                best_g = 0;
                for (int g = 0; g < n_glyphs; g++) begin
                    sad = 0;
                    sd  = 0;
                    for (int p = 0; p < gtbm_pkg::PIX_PER_GLYPH; p++) begin
                        d   = int'(tile_shadow[p])
                            - int'(font_shadow[g * gtbm_pkg::PIX_PER_GLYPH + p]);
                        sd  = sd + d;
                        sad = sad + ((d < 0) ? -d : d);
                    end
                    if (sd < 0)
                        sd = -sd;
                    if (cur_mode == gtbm_pkg::MODE_SAD)
                        score = sad;
                    else
                        score = sad * longint'(cur_abs_w) + sd * longint'(cur_signed_w);
                    if (score < best) begin
                        best   = score;
                        best_g = g;
                    end
                end
                if (best > longint'(24'hFFFFFF))
                    best = longint'(24'hFFFFFF);
                m.glyph = gtbm_pkg::IDX_BITS'(best_g);
                m.score = gtbm_pkg::SCORE_OUT_BITS'(best);
                pending_matches.push_back(m);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver. A request is taken at an edge with start high and busy
    // low; only then, or when start is already low, is the next one loaded.
    // Random idle cycles are inserted at idle_pct percent.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : request_driver
        logic free;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            free = !start;
            if (start && !busy) begin
                score_request(req_on_bus);
                free = 1'b1;
            end
            if (free) begin
                if (pixel_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    req_on_bus     = pixel_requests.pop_front();
                    i_command     <= req_on_bus.cmd;
                    i_glyph_index <= req_on_bus.glyph;
                    i_pixel_index <= req_on_bus.pix;
                    i_pixel_value <= req_on_bus.val;
                    i_tile_done   <= req_on_bus.done;
                    start         <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: the strobe lasts one cycle and cannot be held off, so
    // every strobed cycle is checked against the oldest expected match.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_match want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_matches.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result: expected none, actual glyph %0d score %0d",
                         $time, o_best_glyph, o_best_score);
            end else begin
                want = pending_matches.pop_front();
                if (o_best_glyph !== want.glyph) begin
                    fail_count++;
                    $display("%0t: best_glyph mismatch: expected %0d, actual %0d",
                             $time, want.glyph, o_best_glyph);
                end
                if (o_best_score !== want.score) begin
                    fail_count++;
                    $display("%0t: best_score mismatch: expected %0d, actual %0d",
                             $time, want.score, o_best_score);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int clamp_pix(input int v);
        return (v < 0) ? 0 : ((v > gtbm_pkg::PIX_MAX) ? gtbm_pkg::PIX_MAX : v);
    endfunction

    function automatic int near_value(input int v, input int spread);
        return clamp_pix(v + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic int pick_weight();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return 0;
        if (r == 1)
            return 255;
        return $urandom_range(0, 255);
    endfunction

    task automatic push_req(input logic cmd, input int g, input int p, input int v,
                            input logic done);
        t_pixel_req r;
        r.cmd   = cmd;
        r.glyph = gtbm_pkg::IDX_BITS'(g);
        r.pix   = gtbm_pkg::IDX_BITS'(p);
        r.val   = gtbm_pkg::PIX_BITS'(v);
        r.done  = done;
        if (cmd == gtbm_pkg::CMD_TILE && p < gtbm_pkg::PIX_PER_GLYPH)
            gen_tile[p] = r.val;
        pixel_requests.push_back(r);
    endtask

    // Full tile write; the last pixel can carry the done flag
    task automatic fill_tile(input t_fill_style style, input int level, input logic last_done);
        int v;
        for (int p = 0; p < gtbm_pkg::PIX_PER_GLYPH; p++) begin
            v = (style == FILL_FLAT) ? level : $urandom_range(0, 255);
            push_req(gtbm_pkg::CMD_TILE, 0, p, v,
                     last_done && (p == gtbm_pkg::PIX_PER_GLYPH - 1));
        end
    endtask

    // Full glyph write; done flag is random since the block ignores it here
    task automatic fill_glyph(input int g, input t_fill_style style, input int level);
        int v;
        for (int p = 0; p < gtbm_pkg::PIX_PER_GLYPH; p++) begin
            case (style)
                FILL_FLAT:      v = level;
                FILL_TILE:      v = int'(gen_tile[p]);
                FILL_NEAR_TILE: v = near_value(int'(gen_tile[p]), level);
                default:        v = $urandom_range(0, 255);
            endcase
            push_req(gtbm_pkg::CMD_FONT, g, p, v, 1'($urandom_range(0, 1)));
        end
    endtask

    // Wait until the queue is drained, nothing is outstanding and the block
    // is idle, over consecutive samples. Sampled on the falling edge to avoid races.
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (quiet < 8) begin
            @(negedge i_clk);
            if (pixel_requests.size() == 0 && !start && pending_matches.size() == 0 && !busy)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    task automatic write_reg(input logic [gtbm_pkg::CFG_IDX_BITS-1:0] idx, input int data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= gtbm_pkg::CFG_DATA_BITS'(data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            gtbm_pkg::CFG_MATCH_MODE:    cur_mode     = 1'(data);
            gtbm_pkg::CFG_ABS_WEIGHT:    cur_abs_w    = gtbm_pkg::WEIGHT_BITS'(data);
            gtbm_pkg::CFG_SIGNED_WEIGHT: cur_signed_w = gtbm_pkg::WEIGHT_BITS'(data);
            gtbm_pkg::CFG_GLYPH_COUNT:   cur_count    = gtbm_pkg::CFG_DATA_BITS'(data);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Mode bit goes in with random upper bits; only bit 0 counts
    task automatic apply_setting(input logic mode, input int abs_w, input int sgn_w,
                                 input int count);
        write_reg(gtbm_pkg::CFG_MATCH_MODE, int'({7'($urandom_range(0, 127)), mode}));
        write_reg(gtbm_pkg::CFG_ABS_WEIGHT, abs_w);
        write_reg(gtbm_pkg::CFG_SIGNED_WEIGHT, sgn_w);
        write_reg(gtbm_pkg::CFG_GLYPH_COUNT, count);
    endtask

    task automatic random_request();
        int r;
        int p;
        int g;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, gtbm_pkg::PIX_PER_GLYPH - 1);
        if (r < 8) begin
            // starts a match
            push_req(gtbm_pkg::CMD_TILE, $urandom_range(0, 127), p,
                     ($urandom_range(0, 1) != 0) ? near_value(int'(gen_tile[p]), 20)
                                                 : $urandom_range(0, 255), 1'b1);
        end else if (r < 50) begin
            push_req(gtbm_pkg::CMD_TILE, $urandom_range(0, 127), p,
                     $urandom_range(0, 255), 1'b0);
        end else begin
            // bias font writes toward low glyphs and toward the tile, so that
            // small searches see close scores and near ties
            g = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 127);
            push_req(gtbm_pkg::CMD_FONT, g, p,
                     ($urandom_range(0, 1) != 0) ? near_value(int'(gen_tile[p]), 2)
                                                 : $urandom_range(0, 255),
                     1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int count;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Zero glyph count: the result is glyph 0 at the starting score
        write_reg(gtbm_pkg::CFG_GLYPH_COUNT, 0);
        fill_tile(FILL_RANDOM, 0, 1'b0);
        push_req(gtbm_pkg::CMD_TILE, 0, 0, 0, 1'b0);
        push_req(gtbm_pkg::CMD_TILE, 127, 1, 255, 1'b1);
        // done flag on a font write gives no result
        push_req(gtbm_pkg::CMD_FONT, 0, 0, 255, 1'b1);
        // glyph 0 all white, glyph 1 all black, glyphs 2 and 3 equal to tile
        fill_glyph(0, FILL_FLAT, 255);
        fill_glyph(1, FILL_FLAT, 0);
        fill_glyph(2, FILL_TILE, 0);
        fill_glyph(3, FILL_TILE, 0);
        wait_idle();

        // exact match and tie: glyph 2 wins over glyph 3
        write_reg(gtbm_pkg::CFG_GLYPH_COUNT, 4);
        push_req(gtbm_pkg::CMD_TILE, 0, 5, int'(gen_tile[5]), 1'b1);
        push_req(gtbm_pkg::CMD_TILE, 0, 5, int'(gen_tile[5] ^ 8'h80), 1'b1);
        push_req(gtbm_pkg::CMD_TILE, 0, 5, int'(gen_tile[5] ^ 8'h80), 1'b1);
        wait_idle();

        // weighted with full weights
        apply_setting(gtbm_pkg::MODE_WEIGHTED, 255, 255, 4);
        push_req(gtbm_pkg::CMD_TILE, 0, 9, 255 - int'(gen_tile[9]), 1'b1);
        wait_idle();

        // zero weights: every score equals the start, nothing replaces it
        apply_setting(gtbm_pkg::MODE_WEIGHTED, 0, 0, 4);
        push_req(gtbm_pkg::CMD_TILE, 0, 9, int'(gen_tile[9]), 1'b1);
        wait_idle();

        // black tile against white glyph: score ties the start, glyph 0 kept
        apply_setting(gtbm_pkg::MODE_SAD, 1, 1, 1);
        fill_tile(FILL_FLAT, 0, 1'b1);
        wait_idle();

        // Random phases under changing settings over the loaded glyphs,
        // extremes first
        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            case (ph)
                0: apply_setting(gtbm_pkg::MODE_SAD, 1, 1, 4);
                1: apply_setting(gtbm_pkg::MODE_WEIGHTED, 255, 255, 4);
                2: apply_setting(gtbm_pkg::MODE_WEIGHTED, 0, 255, 3);
                3: apply_setting(gtbm_pkg::MODE_WEIGHTED, 255, 0, 0);
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1:    count = 0;
                        default: count = $urandom_range(1, 4);
                    endcase
                    apply_setting(1'($urandom_range(0, 1)), pick_weight(), pick_weight(),
                                  count);
                end
            endcase
            idle_pct = (ph == 4) ? 0 : 30;
            repeat ((ph == 4) ? 40 : 10) random_request();
            push_req(gtbm_pkg::CMD_TILE, 0, $urandom_range(0, 127), $urandom_range(0, 255),
                     1'b1);
        end

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (pending_matches.size() != 0) begin
            fail_count++;
            $display("%0t: results missing: expected %0d more, actual 0",
                     $time, pending_matches.size());
        end
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hang guard, far above the slowest legal run
    initial begin : watchdog
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
